>>> rtl/core/scar_pkg.sv
// ----------------------------------------------------------------------------
// scar_pkg: shared types and constants of the stereo comb/allpass reverb core
// Holds the beat types, register indexes and delay line geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package scar_pkg;

   localparam int PREDELAY_LEN = 2048;
   localparam int COMB0_LEN    = 4096;
   localparam int COMB1_LEN    = 4096;
   localparam int ALLPASS_LEN  = 1024;
   localparam int EARLY_LEN    = 2048;

   // Ring position widths; a line of length one still gets a one-bit position.
   localparam int PD_AW = (PREDELAY_LEN > 1) ? $clog2(PREDELAY_LEN) : 1;
   localparam int C0_AW = (COMB0_LEN > 1)    ? $clog2(COMB0_LEN)    : 1;
   localparam int C1_AW = (COMB1_LEN > 1)    ? $clog2(COMB1_LEN)    : 1;
   localparam int AP_AW = (ALLPASS_LEN > 1)  ? $clog2(ALLPASS_LEN)  : 1;
   localparam int ER_AW = (EARLY_LEN > 1)    ? $clog2(EARLY_LEN)    : 1;

   localparam int MAX_AW_A = (PD_AW > C0_AW) ? PD_AW : C0_AW;
   localparam int MAX_AW_B = (C1_AW > AP_AW) ? C1_AW : AP_AW;
   localparam int MAX_AW_C = (MAX_AW_A > MAX_AW_B) ? MAX_AW_A : MAX_AW_B;
   localparam int MAX_AW   = (MAX_AW_C > ER_AW) ? MAX_AW_C : ER_AW;
   // Each memory holds both channels: the channel is the top address bit.
   localparam int CLR_AW   = MAX_AW + 1;

   localparam int Q_SHIFT = 7;

   localparam logic [2:0] REG_ENABLE     = 3'd0;
   localparam logic [2:0] REG_COMB0_GAIN = 3'd1;
   localparam logic [2:0] REG_COMB1_GAIN = 3'd2;
   localparam logic [2:0] REG_AP_GAIN    = 3'd3;
   localparam logic [2:0] REG_LP_IN_GAIN = 3'd4;
   localparam logic [2:0] REG_LP_FB_GAIN = 3'd5;
   localparam logic [2:0] REG_EARLY_GAIN = 3'd6;
   localparam logic [2:0] REG_WET_GAIN   = 3'd7;

   typedef struct packed {
      logic signed [31:0] left_in;
      logic signed [31:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_out;
      logic signed [31:0] right_out;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/stereo_comb_allpass_reverb_core.sv
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_core: two-channel Schroeder-style reverb
// Pre-delay, two feedback combs, allpass, one-pole low-pass and early tap.
// ----------------------------------------------------------------------------
// After reset the core first clears all delay memories, one address per cycle
// until every address is zero; req_stall stays high during that pass while
// configuration writes are taken as usual. When enabled, each stereo beat is
// accepted, then per channel takes one memory read and a run of gain steps on
// the single shared 32x8 multiplier that does all gain scaling, and is then
// handed to the output register. With enable low a beat passes straight to
// the output register and no state changes. The result sits in an output
// register, so a new beat is accepted while the previous result is still
// stalled on the rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_comb_allpass_reverb_core
   import scar_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_MC0, S_MC1, S_MAP, S_APIN, S_MAP2,
      S_F2, S_MLP1, S_MLP2, S_LP, S_MW, S_ME, S_OUT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic       enable_ff;
   logic [7:0] g_c0_ff, g_c1_ff, g_ap_ff, g_lpi_ff, g_lpf_ff, g_er_ff, g_wet_ff;

   // Control state.
   logic              ch_ff, ch_in;
   logic [CLR_AW-1:0] clr_ff, clr_in;
   logic [PD_AW-1:0]  pd_pos_ff, pd_pos_in;
   logic [C0_AW-1:0]  c0_pos_ff, c0_pos_in;
   logic [C1_AW-1:0]  c1_pos_ff, c1_pos_in;
   logic [AP_AW-1:0]  ap_pos_ff, ap_pos_in;
   logic [ER_AW-1:0]  er_pos_ff, er_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   req_type     in_ff, in_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] last_ff [2];
   logic [31:0] last_in;
   logic        last_we;
   logic [31:0] ap_in_ff, ap_in_in;
   logic [31:0] f2_ff, f2_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] lp_ff, lp_in;
   logic [31:0] out_l_ff, out_l_in;

   // Shared multiplier.
   logic [31:0] mul_x;
   logic [7:0]  mul_g;
   logic        mul_sm;
   logic [31:0] mul_mag;
   logic [31:0] mul_full;
   logic [31:0] prod_ff;
   logic        neg_ff;
   logic [31:0] prod_asr;
   logic [31:0] fin;

   // Memories.
   logic [31:0] pd_mem [2**(PD_AW+1)];
   logic [31:0] c0_mem [2**(C0_AW+1)];
   logic [31:0] c1_mem [2**(C1_AW+1)];
   logic [31:0] ap_mem [2**(AP_AW+1)];
   logic [31:0] er_mem [2**(ER_AW+1)];
   logic [31:0] pd_q, c0_q, c1_q, ap_q, er_q;
   logic        clearing, rd_en;
   logic        pd_we, c0_we, c1_we, ap_we, er_we;
   logic [31:0] pd_wd, c0_wd, c1_wd, ap_wd, er_wd;
   logic [PD_AW:0] pd_a;
   logic [C0_AW:0] c0_a;
   logic [C1_AW:0] c1_a;
   logic [AP_AW:0] ap_a;
   logic [ER_AW:0] er_a;
   logic [31:0] cur_in;
   logic [31:0] sum;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign clearing = (state_ff == S_CLEAR);
   assign rd_en    = (state_ff == S_RD);
   assign cur_in   = ch_ff ? in_ff.right_in : in_ff.left_in;

   // One address per memory: the clearing sweep, or this channel's ring slot.
   assign pd_a = clearing ? clr_ff[PD_AW:0] : {ch_ff, pd_pos_ff};
   assign c0_a = clearing ? clr_ff[C0_AW:0] : {ch_ff, c0_pos_ff};
   assign c1_a = clearing ? clr_ff[C1_AW:0] : {ch_ff, c1_pos_ff};
   assign ap_a = clearing ? clr_ff[AP_AW:0] : {ch_ff, ap_pos_ff};
   assign er_a = clearing ? clr_ff[ER_AW:0] : {ch_ff, er_pos_ff};

   // Finishing half of sign-magnitude scaling on the registered product.
   assign prod_asr = 32'($signed(prod_ff) >>> Q_SHIFT);
   assign fin      = neg_ff ? (32'd0 - prod_asr) : prod_asr;
   assign sum      = acc_ff + prod_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_x  = c0_q;
      mul_g  = g_c0_ff;
      mul_sm = 1'b1;
      case (state_ff)
         S_MC1: begin
            mul_x = c1_q;
            mul_g = g_c1_ff;
         end
         S_MAP: begin
            mul_x = ap_q;
            mul_g = g_ap_ff;
         end
         S_MAP2: begin
            mul_x = ap_in_ff;
            mul_g = g_ap_ff;
         end
         S_MLP1: begin
            mul_x  = f2_ff;
            mul_g  = g_lpi_ff;
            mul_sm = 1'b0;
         end
         S_MLP2: begin
            mul_x  = last_ff[ch_ff];
            mul_g  = g_lpf_ff;
            mul_sm = 1'b0;
         end
         S_MW: begin
            mul_x  = lp_ff;
            mul_g  = g_wet_ff;
            mul_sm = 1'b0;
         end
         S_ME: begin
            mul_x  = er_q;
            mul_g  = g_er_ff;
            mul_sm = 1'b0;
         end
         default: begin
         end
      endcase
      mul_mag  = (mul_sm && mul_x[31]) ? (32'd0 - mul_x) : mul_x;
      mul_full = 32'(mul_mag * mul_g);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full;
      neg_ff  <= mul_sm & mul_x[31];
   end

   // Memory write enables and data.
   always_comb begin
      pd_we = clearing || (state_ff == S_MC0);
      er_we = pd_we;
      c0_we = clearing || (state_ff == S_MC1);
      c1_we = clearing || (state_ff == S_MAP);
      ap_we = clearing || (state_ff == S_APIN);
      pd_wd = clearing ? 32'd0 : cur_in;
      er_wd = pd_wd;
      c0_wd = clearing ? 32'd0 : (pd_q + fin);
      c1_wd = c0_wd;
      ap_wd = clearing ? 32'd0 : (fin + c0_q - c1_q);
   end

   always_ff @(posedge clock) begin
      if (pd_we) pd_mem[pd_a] <= pd_wd;
      if (rd_en) pd_q <= pd_mem[pd_a];
   end
   always_ff @(posedge clock) begin
      if (c0_we) c0_mem[c0_a] <= c0_wd;
      if (rd_en) c0_q <= c0_mem[c0_a];
   end
   always_ff @(posedge clock) begin
      if (c1_we) c1_mem[c1_a] <= c1_wd;
      if (rd_en) c1_q <= c1_mem[c1_a];
   end
   always_ff @(posedge clock) begin
      if (ap_we) ap_mem[ap_a] <= ap_wd;
      if (rd_en) ap_q <= ap_mem[ap_a];
   end
   always_ff @(posedge clock) begin
      if (er_we) er_mem[er_a] <= er_wd;
      if (rd_en) er_q <= er_mem[er_a];
   end

   // Sequencer: next state and datapath register updates.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      clr_in       = clr_ff;
      pd_pos_in    = pd_pos_ff;
      c0_pos_in    = c0_pos_ff;
      c1_pos_in    = c1_pos_ff;
      ap_pos_in    = ap_pos_ff;
      er_pos_in    = er_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      in_in        = in_ff;
      ap_in_in     = ap_in_ff;
      f2_in        = f2_ff;
      acc_in       = acc_ff;
      lp_in        = lp_ff;
      out_l_in     = out_l_ff;
      last_in      = 32'($signed(sum) >>> Q_SHIFT);
      last_we      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               in_in    = req_data;
               ch_in    = 1'b0;
               out_l_in = req_data.left_in;
               state_in = enable_ff ? S_RD : S_DONE;
            end
         end
         S_RD:   state_in = S_MC0;
         S_MC0:  state_in = S_MC1;
         S_MC1:  state_in = S_MAP;
         S_MAP:  state_in = S_APIN;
         S_APIN: begin
            ap_in_in = ap_wd;
            state_in = S_MAP2;
         end
         S_MAP2: state_in = S_F2;
         S_F2: begin
            f2_in    = ap_q - fin;
            state_in = S_MLP1;
         end
         S_MLP1: state_in = S_MLP2;
         S_MLP2: begin
            acc_in   = prod_ff;
            state_in = S_LP;
         end
         S_LP: begin
            lp_in    = last_in;
            last_we  = 1'b1;
            state_in = S_MW;
         end
         S_MW: state_in = S_ME;
         S_ME: begin
            acc_in   = prod_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ch_ff) begin
               out_l_in = last_in;
               ch_in    = 1'b1;
               state_in = S_RD;
            end else begin
               lp_in     = last_in;
               pd_pos_in = (32'(pd_pos_ff) == PREDELAY_LEN - 1) ? '0 : pd_pos_ff + 1'b1;
               c0_pos_in = (32'(c0_pos_ff) == COMB0_LEN - 1)    ? '0 : c0_pos_ff + 1'b1;
               c1_pos_in = (32'(c1_pos_ff) == COMB1_LEN - 1)    ? '0 : c1_pos_ff + 1'b1;
               ap_pos_in = (32'(ap_pos_ff) == ALLPASS_LEN - 1)  ? '0 : ap_pos_ff + 1'b1;
               er_pos_in = (32'(er_pos_ff) == EARLY_LEN - 1)    ? '0 : er_pos_ff + 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.left_out    = out_l_ff;
               rsp_in.right_out   = enable_ff ? lp_ff : in_ff.right_in;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ch_ff        <= 1'b0;
         clr_ff       <= '0;
         pd_pos_ff    <= '0;
         c0_pos_ff    <= '0;
         c1_pos_ff    <= '0;
         ap_pos_ff    <= '0;
         er_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         clr_ff       <= clr_in;
         pd_pos_ff    <= pd_pos_in;
         c0_pos_ff    <= c0_pos_in;
         c1_pos_ff    <= c1_pos_in;
         ap_pos_ff    <= ap_pos_in;
         er_pos_ff    <= er_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (last_we) last_ff[ch_ff] <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      in_ff    <= in_in;
      ap_in_ff <= ap_in_in;
      f2_ff    <= f2_in;
      acc_ff   <= acc_in;
      lp_ff    <= lp_in;
      out_l_ff <= out_l_in;
   end

   // Configuration registers; the low data bit alone carries enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         g_c0_ff   <= '0;
         g_c1_ff   <= '0;
         g_ap_ff   <= '0;
         g_lpi_ff  <= '0;
         g_lpf_ff  <= '0;
         g_er_ff   <= '0;
         g_wet_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ENABLE:     enable_ff <= csr_wdata[0];
            REG_COMB0_GAIN: g_c0_ff   <= csr_wdata;
            REG_COMB1_GAIN: g_c1_ff   <= csr_wdata;
            REG_AP_GAIN:    g_ap_ff   <= csr_wdata;
            REG_LP_IN_GAIN: g_lpi_ff  <= csr_wdata;
            REG_LP_FB_GAIN: g_lpf_ff  <= csr_wdata;
            REG_EARLY_GAIN: g_er_ff   <= csr_wdata;
            REG_WET_GAIN:   g_wet_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/scar_checker.sv
// ----------------------------------------------------------------------------
// scar_checker: port-level checks for the reverb core
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module scar_checker
   import scar_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // The core works on one beat at a time.
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken in two consecutive cycles");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // Reset leaves no result pending and no request being taken.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("core not quiet after reset");

endmodule

bind stereo_comb_allpass_reverb_core scar_checker u_scar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> verif/tb_stereo_comb_allpass_reverb_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_comb_allpass_reverb_core: self-checking bench of the reverb core
// Drives random and directed stereo beats under several gain settings with
// random idling on both sides, predicts every result with a behavioral copy
// of the reverb chain and compares each rsp beat against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stereo_comb_allpass_reverb_core;
   import scar_pkg::*;

   // Behavioral reverb: holds its own delay lines, positions and gains.
   class reverb_scoreboard;
      logic [31:0] pd_line [2][PREDELAY_LEN];
      logic [31:0] c0_line [2][COMB0_LEN];
      logic [31:0] c1_line [2][COMB1_LEN];
      logic [31:0] ap_line [2][ALLPASS_LEN];
      logic [31:0] er_line [2][EARLY_LEN];
      logic [31:0] lp_last [2];
      int pd_pos, c0_pos, c1_pos, ap_pos, er_pos;
      logic        en;
      logic [7:0]  gains [1:7];
      rsp_type     pending [$];
      int          errors;

      function new();
         foreach (pd_line[c, i]) pd_line[c][i] = '0;
         foreach (c0_line[c, i]) c0_line[c][i] = '0;
         foreach (c1_line[c, i]) c1_line[c][i] = '0;
         foreach (ap_line[c, i]) ap_line[c][i] = '0;
         foreach (er_line[c, i]) er_line[c][i] = '0;
         foreach (lp_last[c]) lp_last[c] = '0;
         pd_pos = 0; c0_pos = 0; c1_pos = 0; ap_pos = 0; er_pos = 0;
         en = 1'b0;
         for (int i = 1; i < 8; i++) gains[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] val);
         if (idx == REG_ENABLE) en = val[0];
         else gains[idx] = val;
      endfunction

      function logic [31:0] shr7(logic [31:0] v);
         return $signed(v) >>> Q_SHIFT;
      endfunction

      // Sign-magnitude gain scaling, truncating toward zero.
      function logic [31:0] gain_scale(logic [31:0] x, logic [7:0] g);
         logic [31:0] mag, r;
         mag = x[31] ? -x : x;
         r = shr7(mag * {24'd0, g});
         return x[31] ? -r : r;
      endfunction

      function logic [31:0] channel(int ch, logic [31:0] x);
         logic [31:0] pd, c0, c1, f, ap_old, ap_in, lp, tap;
         pd = pd_line[ch][pd_pos];
         pd_line[ch][pd_pos] = x;
         c0 = c0_line[ch][c0_pos];
         c0_line[ch][c0_pos] = pd + gain_scale(c0, gains[REG_COMB0_GAIN]);
         c1 = c1_line[ch][c1_pos];
         c1_line[ch][c1_pos] = pd + gain_scale(c1, gains[REG_COMB1_GAIN]);
         f = c0 - c1;
         ap_old = ap_line[ch][ap_pos];
         ap_in = gain_scale(ap_old, gains[REG_AP_GAIN]) + f;
         ap_line[ch][ap_pos] = ap_in;
         f = ap_old - gain_scale(ap_in, gains[REG_AP_GAIN]);
         lp = shr7(f * {24'd0, gains[REG_LP_IN_GAIN]}
                   + lp_last[ch] * {24'd0, gains[REG_LP_FB_GAIN]});
         lp_last[ch] = lp;
         tap = er_line[ch][er_pos] * {24'd0, gains[REG_EARLY_GAIN]};
         er_line[ch][er_pos] = x;
         return shr7(lp * {24'd0, gains[REG_WET_GAIN]} + tap);
      endfunction

      function void note_input(req_type r);
         rsp_type e;
         if (en) begin
            e.left_out  = channel(0, r.left_in);
            e.right_out = channel(1, r.right_in);
            pd_pos = (pd_pos + 1 == PREDELAY_LEN) ? 0 : pd_pos + 1;
            c0_pos = (c0_pos + 1 == COMB0_LEN) ? 0 : c0_pos + 1;
            c1_pos = (c1_pos + 1 == COMB1_LEN) ? 0 : c1_pos + 1;
            ap_pos = (ap_pos + 1 == ALLPASS_LEN) ? 0 : ap_pos + 1;
            er_pos = (er_pos + 1 == EARLY_LEN) ? 0 : er_pos + 1;
         end else begin
            e.left_out  = r.left_in;
            e.right_out = r.right_in;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected rsp beat %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.left_out !== e.left_out) begin
            $display("%0t: left_out expected %h actual %h", $time, e.left_out, got.left_out);
            errors++;
         end
         if (got.right_out !== e.right_out) begin
            $display("%0t: right_out expected %h actual %h", $time, e.right_out,
                     got.right_out);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   reverb_scoreboard board;
   int send_idle_pct = 0;   // chance in percent that the sender skips a cycle
   int recv_stall_pct = 0;  // chance in percent that the receiver stalls

   always #6 clock = ~clock;

   stereo_comb_allpass_reverb_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Receiver: stall changes on the falling edge, results are taken at the
   // rising edge where valid is high and stall is low.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // One configuration write; the block is idle whenever this is called.
   task automatic write_csr(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sends one beat, with a random idle gap ahead of it. The prediction is
   // made at the accepting edge so the scoreboard order follows the block.
   task automatic send_beat(logic [31:0] l, logic [31:0] r);
      req_type b;
      b.left_in  = l;
      b.right_in = r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      board.note_input(b);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Waits until every predicted beat came back, then lets the pipe settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Mostly moderate samples keep the tail audible; some full-range values
   // exercise the wrap and the most negative magnitude.
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3:    return $urandom();
         default: return $signed($urandom_range(65535)) - 32768;
      endcase
   endfunction

   task automatic program_gains(logic [7:0] g1, logic [7:0] g2, logic [7:0] g3,
                                logic [7:0] g4, logic [7:0] g5, logic [7:0] g6,
                                logic [7:0] g7);
      write_csr(REG_COMB0_GAIN, g1);
      write_csr(REG_COMB1_GAIN, g2);
      write_csr(REG_AP_GAIN,    g3);
      write_csr(REG_LP_IN_GAIN, g4);
      write_csr(REG_LP_FB_GAIN, g5);
      write_csr(REG_EARLY_GAIN, g6);
      write_csr(REG_WET_GAIN,   g7);
   endtask

   // Timeout: allows far more time than the 1043 beats, the worst stalls and
   // the clearing pass after reset need.
   initial begin
      #(12 * 2000000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Disabled: beats pass straight through, extremes included.
      send_beat(32'h8000_0000, 32'h7fff_ffff);
      send_beat(32'h7fff_ffff, 32'h8000_0000);
      send_beat(32'h0000_0000, 32'hffff_ffff);
      drain();

      // Full-scale gains, then values above 128 that wrap without saturation.
      program_gains(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
      write_csr(REG_ENABLE, 8'd1);
      send_beat(32'h8000_0000, 32'h7fff_ffff);
      send_beat(32'h7fff_ffff, 32'h8000_0000);
      send_beat(32'hffff_ffff, 32'h0000_0001);
      send_beat(32'h0000_0000, 32'h0000_0000);
      drain();
      program_gains(8'd255, 8'd200, 8'd255, 8'd129, 8'd255, 8'd255, 8'd255);
      for (int i = 0; i < 8; i++) send_beat($urandom(), $urandom());
      drain();
      // Freeze in the middle of a tail, then resume where it stopped.
      write_csr(REG_ENABLE, 8'd0);
      send_beat(32'h1234_5678, 32'h8765_4321);
      send_beat(32'h8000_0000, 32'h8000_0000);
      drain();
      write_csr(REG_ENABLE, 8'd1);
      program_gains(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(32'h8000_0000, 32'h7fff_ffff);
      send_beat(32'h4000_0000, 32'hc000_0000);
      drain();

      // Random phases across idling profiles and gain settings. Even all phases
      // together walk no line past its wrap point.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         if (phase == 7) begin
            program_gains(8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128);
         end else begin
            program_gains(8'($urandom_range(128)), 8'($urandom_range(128)),
                          8'($urandom_range(128)), 8'($urandom_range(128)),
                          8'($urandom_range(128)), 8'($urandom_range(128)),
                          8'($urandom_range(255)));
         end
         write_csr(REG_ENABLE, (phase == 5) ? 8'd0 : 8'd1);
         for (int i = 0; i < 128; i++) begin
            // Hold the sender once until every result is back.
            if (phase == 3 && i == 64)
               while (board.pending.size() != 0) @(posedge clock);
            send_beat(pick_sample(), pick_sample());
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> stereo_comb_allpass_reverb_core.f
rtl/core/scar_pkg.sv
rtl/core/stereo_comb_allpass_reverb_core.sv
rtl/core/scar_checker.sv
verif/tb_stereo_comb_allpass_reverb_core.sv
